FILE: design/mld_pkg.sv
// Shared types and constants for the mip level downsampler.
`timescale 1ns / 1ps
package mld_pkg;

	localparam int TEXEL_W = 24;
	localparam int DIM_W_W = 14;
	localparam int DIM_H_W = 16;
	localparam int POS_W   = 16;

	typedef logic [TEXEL_W-1:0] texel_t;

	// Effective level dimensions after clamping
	typedef struct packed {
		logic [DIM_W_W-1:0] width;
		logic [DIM_H_W-1:0] height;
	} dims_t;

	// One reduced texel request: 3x3 window and its output position
	typedef struct packed {
		texel_t [8:0]     window;
		logic [POS_W-1:0] col_idx;
		logic [POS_W-1:0] row_idx;
		logic             last;
	} job_t;

	typedef enum logic {
		FR_TAKE,
		FR_LOAD
	} front_state_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SETUP,
		BK_DIV,
		BK_MUL,
		BK_ACC,
		BK_FIN,
		BK_OUT
	} back_state_t;

	localparam logic [1:0] DIV_H_LEFT  = 2'd0;
	localparam logic [1:0] DIV_H_RIGHT = 2'd1;
	localparam logic [1:0] DIV_V_TOP   = 2'd2;
	localparam logic [1:0] DIV_V_BOT   = 2'd3;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

endpackage

FILE: design/mld_front.sv
// Front end: texel intake, line stores, 3x3 window and request classification.
`timescale 1ns / 1ps
module mld_front #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mld_pkg::dims_t  dims,
	input  logic            cfg_wr,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      red,
	input  logic [7:0]      green,
	input  logic [7:0]      blue,
	input  logic            q_full,
	output logic            push,
	output mld_pkg::job_t   push_job
);
	import mld_pkg::*;

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	front_state_t       state_q, state_d;
	logic [COL_W-1:0]   col_q;
	logic [POS_W-1:0]   row_q;
	logic [COL_W-1:0]   col_s1;
	logic [POS_W-1:0]   row_s1;
	texel_t             texel_s1;
	logic [2*TEXEL_W-1:0] rd_s1;
	logic [2*TEXEL_W-1:0] mem [MAX_WIDTH];
	texel_t [8:0]       window_q;
	logic               accept;
	logic               load;
	logic [DIM_W_W-1:0] cx, hoff, cdiff, ow;
	logic [POS_W-1:0]   ry, voff, rdiff, oh;
	logic [POS_W-1:0]   col_idx, row_idx;
	logic               emit;

	assign accept = in_valid && in_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FR_TAKE: if (accept) state_d = FR_LOAD;
			FR_LOAD: state_d = FR_TAKE;
			default: state_d = FR_TAKE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready = 1'b0;
		load     = 1'b0;
		unique case (state_q)
			FR_TAKE: in_ready = !q_full;
			FR_LOAD: load = 1'b1;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FR_TAKE;
		else state_q <= state_d;
	end

	// Advance the source position; restart on a register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (DIM_W_W'(col_q) + DIM_W_W'(1) >= dims.width) begin
				col_q <= '0;
				if (row_q + POS_W'(1) >= dims.height) row_q <= '0;
				else row_q <= row_q + POS_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Capture the texel and read both line stores
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1   <= col_q;
			row_s1   <= row_q;
			texel_s1 <= {blue, green, red};
			rd_s1    <= mem[col_q];
		end
	end

	// Rotate the line stores: newer moves to older, texel becomes newer
	always_ff @(posedge clk) begin
		if (load) mem[col_s1] <= {rd_s1[TEXEL_W-1:0], texel_s1};
	end

	// Shift the window left and load the new column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (load) begin
			for (int k = 0; k < 3; k++) begin
				window_q[k*3]   <= window_q[k*3+1];
				window_q[k*3+1] <= window_q[k*3+2];
			end
			window_q[2] <= rd_s1[2*TEXEL_W-1:TEXEL_W];
			window_q[5] <= rd_s1[TEXEL_W-1:0];
			window_q[8] <= texel_s1;
		end
	end

	// Decide whether this texel completes a reduced texel
	always_comb begin
		cx      = DIM_W_W'(col_s1);
		ry      = row_s1;
		hoff    = (dims.width == DIM_W_W'(1)) ? '0 :
			(dims.width[0] ? DIM_W_W'(2) : DIM_W_W'(1));
		voff    = (dims.height == POS_W'(1)) ? '0 :
			(dims.height[0] ? POS_W'(2) : POS_W'(1));
		cdiff   = cx - hoff;
		rdiff   = ry - voff;
		col_idx = POS_W'(cdiff >> 1);
		row_idx = rdiff >> 1;
		ow      = (dims.width[DIM_W_W-1:1] == '0) ? DIM_W_W'(1) : (dims.width >> 1);
		oh      = (dims.height[POS_W-1:1] == '0) ? POS_W'(1) : (dims.height >> 1);
		emit    = !(dims.width == DIM_W_W'(1) && dims.height == POS_W'(1)) &&
			cx >= hoff && !cdiff[0] && ry >= voff && !rdiff[0];
	end

	assign push = load && emit;

	// Build the request from the updated window
	always_comb begin
		push_job.window = window_q;
		for (int k = 0; k < 3; k++) begin
			push_job.window[k*3]   = window_q[k*3+1];
			push_job.window[k*3+1] = window_q[k*3+2];
		end
		push_job.window[2] = rd_s1[2*TEXEL_W-1:TEXEL_W];
		push_job.window[5] = rd_s1[TEXEL_W-1:0];
		push_job.window[8] = texel_s1;
		push_job.col_idx   = col_idx;
		push_job.row_idx   = row_idx;
		push_job.last      = (col_idx == POS_W'(ow - DIM_W_W'(1))) &&
			(row_idx == oh - POS_W'(1));
	end

endmodule

FILE: design/mld_queue.sv
// Two-entry request queue between front and back ends.
`timescale 1ns / 1ps
module mld_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mld_pkg::job_t push_job,
	output logic          full,
	output logic          empty,
	input  logic          pop,
	output mld_pkg::job_t head
);
	import mld_pkg::*;

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = count_q == 2'd2;
	assign empty = count_q == 2'd0;
	assign head  = slot_q[rd_ptr_q];

	// Store a request
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_job;
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != 2'd2) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != 2'd0) else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
`endif

endmodule

FILE: design/mld_back.sv
// Back end: weight division, 3x3 filter accumulation and output register.
`timescale 1ns / 1ps
module mld_back #(
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mld_pkg::dims_t dims,
	input  logic           empty,
	input  mld_pkg::job_t  head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_red,
	output logic [7:0]     out_green,
	output logic [7:0]     out_blue,
	output logic           last_of_level
);
	import mld_pkg::*;

	localparam int F      = WEIGHT_FRAC_BITS;
	localparam int WT_W   = F + 1;
	localparam int PR_W   = 2 * WT_W;
	localparam int ACC_W  = 2 * F + 10;
	localparam int DVD_W  = F + 16;
	localparam int STEP_W = $clog2(DVD_W + 1);
	localparam logic [WT_W-1:0] UNIT = WT_W'(1) << F;
	localparam logic [WT_W-1:0] HALF = WT_W'(1) << (F - 1);

	back_state_t        state_q, state_d;
	job_t               job_q;
	logic [1:0]         div_sel_q;
	logic [STEP_W-1:0]  step_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [16:0]        rem_q;
	logic [15:0]        den_q;
	logic [WT_W-1:0]    quot_q [4];
	logic [1:0]         row_q, col_q;
	logic [PR_W-1:0]    wt_s1;
	texel_t             tex_s1;
	logic [ACC_W-1:0]   acc_q [3];
	logic [7:0]         res_q [3];
	logic               last_q;
	logic [WT_W-1:0]    wh [3];
	logic [WT_W-1:0]    wv [3];
	logic [15:0]        nh, nv, num, n_sel;
	logic [16:0]        rem_sh, rem_next;
	logic               ge;
	logic               div_done, div_last, tap_last;
	logic [3:0]         tap;

	// Operands for the selected weight division
	always_comb begin
		nh = 16'(dims.width >> 1);
		nv = dims.height >> 1;
		case (div_sel_q)
			DIV_H_LEFT:  begin num = nh - job_q.col_idx; n_sel = nh; end
			DIV_H_RIGHT: begin num = job_q.col_idx + 16'd1; n_sel = nh; end
			DIV_V_TOP:   begin num = nv - job_q.row_idx; n_sel = nv; end
			default:     begin num = job_q.row_idx + 16'd1; n_sel = nv; end
		endcase
	end

	// Restoring divider step
	always_comb begin
		rem_sh   = {rem_q[15:0], dvd_q[DVD_W-1]};
		ge       = rem_sh >= {1'b0, den_q};
		rem_next = ge ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	assign div_done = step_q == STEP_W'(DVD_W - 1);
	assign div_last = div_sel_q == DIV_V_BOT;
	assign tap_last = row_q == 2'd2 && col_q == 2'd2;
	assign tap      = 4'({row_q, 1'b0}) + 4'(row_q) + 4'(col_q);

	// Column and row weights aligned to the window
	always_comb begin
		wh[0] = '0; wh[1] = '0; wh[2] = '0;
		wv[0] = '0; wv[1] = '0; wv[2] = '0;
		if (dims.width == DIM_W_W'(1)) begin
			wh[2] = UNIT;
		end else if (!dims.width[0]) begin
			wh[1] = HALF;
			wh[2] = HALF;
		end else begin
			wh[0] = quot_q[0];
			wh[2] = quot_q[1];
			wh[1] = UNIT - quot_q[0] - quot_q[1];
		end
		if (dims.height == DIM_H_W'(1)) begin
			wv[2] = UNIT;
		end else if (!dims.height[0]) begin
			wv[1] = HALF;
			wv[2] = HALF;
		end else begin
			wv[0] = quot_q[2];
			wv[2] = quot_q[3];
			wv[1] = UNIT - quot_q[2] - quot_q[3];
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:  if (!empty) state_d = BK_SETUP;
			BK_SETUP: state_d = BK_DIV;
			BK_DIV:   if (div_done) state_d = div_last ? BK_MUL : BK_SETUP;
			BK_MUL:   state_d = BK_ACC;
			BK_ACC:   state_d = tap_last ? BK_FIN : BK_MUL;
			BK_FIN:   state_d = BK_OUT;
			BK_OUT:   if (out_ready) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		pop       = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			BK_IDLE: pop = !empty;
			BK_OUT:  out_valid = 1'b1;
			default: pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else state_q <= state_d;
	end

	// Sequence counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_sel_q <= '0;
			step_q    <= '0;
			row_q     <= '0;
			col_q     <= '0;
		end else begin
			case (state_q)
				BK_IDLE: begin
					div_sel_q <= DIV_H_LEFT;
					row_q     <= '0;
					col_q     <= '0;
				end
				BK_SETUP: step_q <= '0;
				BK_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (div_done) div_sel_q <= div_sel_q + 2'd1;
				end
				BK_ACC: begin
					if (col_q == 2'd2) begin
						col_q <= '0;
						row_q <= row_q + 2'd1;
					end else begin
						col_q <= col_q + 2'd1;
					end
				end
				default: step_q <= step_q;
			endcase
		end
	end

	// Datapath: take request, divide, multiply, accumulate
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (!empty) job_q <= head;
				for (int c = 0; c < 3; c++) acc_q[c] <= '0;
			end
			BK_SETUP: begin
				dvd_q <= {num, {F{1'b0}}} + DVD_W'(n_sel);
				rem_q <= '0;
				den_q <= {n_sel[14:0], 1'b1};
			end
			BK_DIV: begin
				rem_q <= rem_next;
				dvd_q <= {dvd_q[DVD_W-2:0], ge};
				if (div_done) quot_q[div_sel_q] <= WT_W'({dvd_q[DVD_W-2:0], ge});
			end
			BK_MUL: begin
				wt_s1  <= wv[row_q] * wh[col_q];
				tex_s1 <= job_q.window[tap];
			end
			BK_ACC: begin
				if (wt_s1 != '0) begin
					for (int c = 0; c < 3; c++)
						acc_q[c] <= acc_q[c] + ACC_W'(wt_s1 * tex_s1[c*8 +: 8]);
				end
			end
			BK_FIN: begin
				for (int c = 0; c < 3; c++) begin
					if (acc_q[c][ACC_W-1:2*F] > (ACC_W-2*F)'(255)) res_q[c] <= 8'hFF;
					else res_q[c] <= acc_q[c][2*F +: 8];
				end
				last_q <= job_q.last;
			end
			default: last_q <= last_q;
		endcase
	end

	assign out_red       = res_q[0];
	assign out_green     = res_q[1];
	assign out_blue      = res_q[2];
	assign last_of_level = last_q;

`ifndef NO_ASSERTIONS
	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == BK_SETUP) else $error("pop did not start a request");
	a_div_sel_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_DIV && $past(state_q) == BK_DIV |-> $stable(div_sel_q))
		else $error("division select moved mid division");
	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_MUL |-> row_q != 2'd3 && col_q != 2'd3)
		else $error("tap index out of window");
`endif

endmodule

FILE: design/mip_level_downsampler_top.sv
// Top level: register port, effective dimensions, front, queue and back end.
// Front end loads each texel before it takes the next and stalls while the queue is full;
// line store read is registered. Back end works on one reduced texel at a time: a serial
// restoring divider computes the weights, then 9 taps of multiply-accumulate follow.
// Reset clears control state and sets both dimensions to 2; line stores stay unset.
`timescale 1ns / 1ps
module mip_level_downsampler_top #(
	parameter int MAX_WIDTH        = 2048,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic        last_of_level
);
	import mld_pkg::*;

	logic [11:0] src_width_q;
	logic [15:0] src_height_q;
	logic [DIM_W_W-1:0] w_raw;
	logic        cfg_wr;
	dims_t       dims;
	logic        push, pop, q_full, q_empty;
	job_t        push_job, head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= 12'd2;
			src_height_q <= 16'd2;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_WIDTH:  src_width_q  <= pwdata[11:0];
				REG_HEIGHT: src_height_q <= pwdata[15:0];
				default:    src_width_q  <= src_width_q;
			endcase
		end
	end

	assign prdata = (paddr[2] == REG_HEIGHT) ? {16'd0, src_height_q} : {20'd0, src_width_q};

	// Clamp dimensions
	always_comb begin
		w_raw       = (src_width_q == '0) ? DIM_W_W'(1) : DIM_W_W'(src_width_q);
		dims.width  = (w_raw > DIM_W_W'(MAX_WIDTH)) ? DIM_W_W'(MAX_WIDTH) : w_raw;
		dims.height = (src_height_q == '0) ? DIM_H_W'(1) : src_height_q;
	end

	mld_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk, .arst_n, .dims, .cfg_wr, .in_valid, .in_ready,
		.red, .green, .blue, .q_full, .push, .push_job
	);

	mld_queue u_queue (
		.clk, .arst_n, .push, .push_job, .full(q_full), .empty(q_empty), .pop, .head
	);

	mld_back #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_back (
		.clk, .arst_n, .dims, .empty(q_empty), .head, .pop, .out_valid, .out_ready,
		.out_red, .out_green, .out_blue, .last_of_level
	);

endmodule

FILE: dv/mld_reduced_texel_checker.sv
// Checker: predicts reduced texels from accepted source texels and compares them.
`timescale 1ns / 1ps
module mld_reduced_texel_checker #(
	parameter int MAX_WIDTH        = 2048,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_red,
	input  logic [7:0]  out_green,
	input  logic [7:0]  out_blue,
	input  logic        last_of_level,
	output int          fail_count,
	output int          pending
);
	import mld_pkg::*;

	localparam logic [2:0] ADDR_WIDTH  = 3'd0;
	localparam logic [2:0] ADDR_HEIGHT = 3'd4;
	localparam longint unsigned UNIT = 64'd1 << WEIGHT_FRAC_BITS;

	typedef struct {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       last;
	} reduced_texel_t;

	reduced_texel_t reduced_q[$];
	texel_t         line_older [MAX_WIDTH];
	texel_t         line_newer [MAX_WIDTH];
	texel_t         win [9];
	logic [11:0]    src_width;
	logic [15:0]    src_height;
	int unsigned    col_pos;
	int unsigned    row_pos;

	assign pending = reduced_q.size();

	function automatic int unsigned tap_total(int unsigned size);
		if (size == 1) return 1;
		return size[0] ? 3 : 2;
	endfunction

	// Fixed-point weights along one dimension for output index idx
	function automatic void filter_weights(input int unsigned size, input int unsigned idx,
			output longint unsigned w0, output longint unsigned w1,
			output longint unsigned w2);
		longint unsigned n, den, k;
		w0 = 0; w1 = 0; w2 = 0;
		if (size == 1) begin
			w0 = UNIT;
		end else if (!size[0]) begin
			w0 = UNIT >> 1;
			w1 = UNIT >> 1;
		end else begin
			n = size >> 1;
			den = 2 * n + 1;
			k = (idx >= n) ? n - 1 : idx;
			w0 = (((n - k) << WEIGHT_FRAC_BITS) + n) / den;
			w2 = (((k + 1) << WEIGHT_FRAC_BITS) + n) / den;
			w1 = UNIT - w0 - w2;
		end
	endfunction

	// Advance the level position for one source texel and queue any reduced texel
	task automatic take_texel(input texel_t tx);
		int unsigned w, h, c, r, nh, nv, i, j, ow, oh;
		longint unsigned wh [3];
		longint unsigned wv [3];
		longint unsigned acc [3];
		longint unsigned wt, v;
		texel_t t;
		reduced_texel_t res;
		w = (src_width == 0) ? 1 : ((src_width > MAX_WIDTH) ? MAX_WIDTH : src_width);
		h = (src_height == 0) ? 1 : src_height;
		c = (col_pos >= w) ? 0 : col_pos;
		r = (row_pos >= h) ? 0 : row_pos;
		for (int k = 0; k < 3; k++) begin
			win[k*3]   = win[k*3+1];
			win[k*3+1] = win[k*3+2];
		end
		win[2] = line_older[c];
		win[5] = line_newer[c];
		win[8] = tx;
		line_older[c] = line_newer[c];
		line_newer[c] = tx;
		nh = tap_total(w);
		nv = tap_total(h);
		if (!(w == 1 && h == 1) && c >= nh - 1 && ((c - (nh - 1)) % 2) == 0 &&
				r >= nv - 1 && ((r - (nv - 1)) % 2) == 0) begin
			i = (w == 1) ? 0 : (c - (nh - 1)) / 2;
			j = (h == 1) ? 0 : (r - (nv - 1)) / 2;
			ow = (w / 2 != 0) ? w / 2 : 1;
			oh = (h / 2 != 0) ? h / 2 : 1;
			filter_weights(w, i, wh[0], wh[1], wh[2]);
			filter_weights(h, j, wv[0], wv[1], wv[2]);
			acc[0] = 0; acc[1] = 0; acc[2] = 0;
			for (int jj = 0; jj < nv; jj++) begin
				for (int ii = 0; ii < nh; ii++) begin
					wt = wv[jj] * wh[ii];
					t = win[(3 - nv + jj) * 3 + (3 - nh + ii)];
					for (int ch = 0; ch < 3; ch++)
						acc[ch] += wt * longint'(t[8*ch +: 8]);
				end
			end
			v = acc[0] >> (2 * WEIGHT_FRAC_BITS); res.r = (v > 255) ? 8'hFF : v[7:0];
			v = acc[1] >> (2 * WEIGHT_FRAC_BITS); res.g = (v > 255) ? 8'hFF : v[7:0];
			v = acc[2] >> (2 * WEIGHT_FRAC_BITS); res.b = (v > 255) ? 8'hFF : v[7:0];
			res.last = (i == ow - 1 && j == oh - 1);
			reduced_q.push_back(res);
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		col_pos = c;
		row_pos = r;
	endtask

	// Watch register writes, source requests and reduced texels
	always @(posedge clk or negedge arst_n) begin
		reduced_texel_t exp_tx;
		if (!arst_n) begin
			src_width  = 12'd2;
			src_height = 16'd2;
			col_pos    = 0;
			row_pos    = 0;
			fail_count = 0;
			for (int k = 0; k < 9; k++) win[k] = '0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_WIDTH) begin
					src_width = pwdata[11:0];
					col_pos = 0; row_pos = 0;
				end else if (paddr == ADDR_HEIGHT) begin
					src_height = pwdata[15:0];
					col_pos = 0; row_pos = 0;
				end
			end
			if (in_valid && in_ready)
				take_texel({blue, green, red});
			if (out_valid && out_ready) begin
				if (reduced_q.size() == 0) begin
					$error("unexpected reduced texel %h %h %h", out_red, out_green, out_blue);
					fail_count++;
				end else begin
					exp_tx = reduced_q.pop_front();
					if (out_red !== exp_tx.r) begin
						$error("out_red expected %0d actual %0d", exp_tx.r, out_red);
						fail_count++;
					end
					if (out_green !== exp_tx.g) begin
						$error("out_green expected %0d actual %0d", exp_tx.g, out_green);
						fail_count++;
					end
					if (out_blue !== exp_tx.b) begin
						$error("out_blue expected %0d actual %0d", exp_tx.b, out_blue);
						fail_count++;
					end
					if (last_of_level !== exp_tx.last) begin
						$error("last_of_level expected %0d actual %0d", exp_tx.last,
							last_of_level);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

FILE: dv/mip_level_downsampler_top_test.sv
// Testbench top: drives source levels and register writes, gives the verdict.
`timescale 1ns / 1ps
module mip_level_downsampler_top_test;

	localparam logic [2:0] ADDR_WIDTH  = 3'd0;
	localparam logic [2:0] ADDR_HEIGHT = 3'd4;
	localparam int SETTLE      = 400;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 460;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0, in_ready;
	logic [7:0]  red = '0, green = '0, blue = '0;
	logic        out_valid, out_ready = 1'b0;
	logic [7:0]  out_red, out_green, out_blue;
	logic        last_of_level;
	int          fail_count, pending;
	int          cycles = 0;
	int          burst_left = 0;
	int          random_sent = 0;

	always #5 clk = ~clk;

	mip_level_downsampler_top uut (.*);

	mld_reduced_texel_checker checker_i (.*);

	// Receiver stall pattern: rotate through four out_ready modes
	always @(posedge clk) begin
		cycles <= cycles + 1;
		case ((cycles / 64) % 4)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= (cycles % 8) < 5;
		endcase
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// Hold off until every reduced texel is out, then reprogram the level size
	task automatic set_level(input logic [31:0] w, input logic [31:0] h);
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
		reg_write(ADDR_WIDTH, w);
		reg_write(ADDR_HEIGHT, h);
	endtask

	function automatic logic [7:0] channel_value();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Send one source texel request; hold valid until accepted, then maybe gap
	task automatic send_texel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		in_valid <= 1'b1; red <= r; green <= g; blue <= b;
		do @(posedge clk); while (!in_ready);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_texels(input int count);
		for (int k = 0; k < count; k++)
			send_texel(channel_value(), channel_value(), channel_value());
	endtask

	initial begin
		int w, h;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset size 2x2: all-zero, all-one and mixed texels, two levels
		send_texel(8'h00, 8'h00, 8'h00);
		send_texel(8'hFF, 8'hFF, 8'hFF);
		send_texel(8'hFF, 8'h00, 8'hFF);
		send_texel(8'h00, 8'hFF, 8'h00);
		send_texels(4);
		// Both dimensions one: nothing comes out
		set_level(1, 1);
		send_texels(3);
		// Width zero and odd height; odd width and height zero
		set_level(0, 3);
		send_texels(3);
		set_level(3, 0);
		send_texels(3);
		// Odd 3x3 trapezoid, saturating texels
		set_level(3, 3);
		for (int k = 0; k < 9; k++) send_texel(8'hFF, 8'hFF, 8'hFF);
		// Tallest height, only a few rows before the next write
		set_level(1, 65535);
		send_texels(5);
		// Width over the maximum clamps to an even maximum: box filter, not trapezoid
		set_level(32'hFFF, 1);
		send_texels(8);

		// Random level sizes, mostly small, one to three levels each
		while (random_sent < RANDOM_ITEMS) begin
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 9);
			h = $urandom_range(1, 9);
			set_level(w, h);
			for (int lv = $urandom_range(1, 3); lv > 0 && random_sent < RANDOM_ITEMS;
					lv--) begin
				send_texels(w * h);
				random_sent += w * h;
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: filelist.f
design/mld_pkg.sv
design/mld_front.sv
design/mld_queue.sv
design/mld_back.sv
design/mip_level_downsampler_top.sv
dv/mld_reduced_texel_checker.sv
dv/mip_level_downsampler_top_test.sv
